>>> src/ppc_pkg.sv
// shared types and codes for the playback position clock
`default_nettype none

package ppc_pkg;

  localparam int unsigned FIELD_BITS = 32;

  typedef enum logic [3:0] {
    MODE_ADVANCE   = 4'd0,
    MODE_START     = 4'd1,
    MODE_STOP      = 4'd2,
    MODE_PAUSE     = 4'd3,
    MODE_RESUME    = 4'd4,
    MODE_SEEK      = 4'd5,
    MODE_RESET     = 4'd6,
    MODE_SET_LOOP  = 4'd7,
    MODE_COUNTDOWN = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PAUSED  = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]            mode;
    logic [FIELD_BITS-1:0] amount;
    logic [FIELD_BITS-1:0] loop_end_value;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] position;
    logic [1:0]            play_status;
    logic                  position_changed;
    logic                  seek_happened;
    logic                  countdown_done;
    logic                  loop_rejected;
  } res_t;

endpackage

`default_nettype wire

>>> src/playback_position_clock_top.sv
// Playback position clock: takes one command transfer per cycle while results are
// taken, and returns one result transfer per command. A command is registered at
// the input; once the output register can take a result, the state update is
// applied and its result is registered at the output. Sustained rate is one
// command per cycle while out_ready stays high; while a result waits on out_ready
// the input register holds one more command and then stops accepting until the
// result is taken.
// track_duration is written through cfg_wr_en/cfg_wr_data and should only be
// changed while no command is in flight. TIME_BITS sets the internal time width;
// inputs are taken modulo 2^TIME_BITS and the position port shows the low 32 bits.
`default_nettype none

module playback_position_clock_top #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [3:0]                     in_mode,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] in_amount,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] in_loop_end_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ppc_pkg::FIELD_BITS-1:0]      out_position,
  output logic [1:0]                          out_play_status,
  output logic                                out_position_changed,
  output logic                                out_seek_happened,
  output logic                                out_countdown_done,
  output logic                                out_loop_rejected
);

  logic          cmd_valid;
  logic          can_take;
  logic          step;
  ppc_pkg::cmd_t cmd;
  ppc_pkg::res_t res;

  assign step = cmd_valid && can_take;

  ppc_in_reg u_in_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_amount         (in_amount),
    .in_loop_end_value (in_loop_end_value),
    .step              (step),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd)
  );

  ppc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .cmd         (cmd),
    .res         (res)
  );

  ppc_out_reg u_out_reg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (step),
    .res                  (res),
    .can_take             (can_take),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_position         (out_position),
    .out_play_status      (out_play_status),
    .out_position_changed (out_position_changed),
    .out_seek_happened    (out_seek_happened),
    .out_countdown_done   (out_countdown_done),
    .out_loop_rejected    (out_loop_rejected)
  );

endmodule

`default_nettype wire

>>> src/ppc_in_reg.sv
// input register holding one command transfer
`default_nettype none

module ppc_in_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [3:0]                     in_mode,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] in_amount,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] in_loop_end_value,
  input  wire logic                           step,
  output logic                                cmd_valid,
  output ppc_pkg::cmd_t                       cmd
);

  logic          valid_r;
  ppc_pkg::cmd_t cmd_r;

  assign in_ready  = !valid_r || step;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.mode           <= in_mode;
      cmd_r.amount         <= in_amount;
      cmd_r.loop_end_value <= in_loop_end_value;
    end
  end

endmodule

`default_nettype wire

>>> src/ppc_core.sv
// position, status, loop and countdown state with the per-command update
`default_nettype none

module ppc_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ppc_pkg::FIELD_BITS-1:0] cfg_wr_data,
  input  wire logic                           step,
  input  wire ppc_pkg::cmd_t                  cmd,
  output ppc_pkg::res_t                       res
);

  localparam int unsigned TB = TIME_BITS;

  logic [TB-1:0]     duration_r;
  logic [TB-1:0]     pos_r, pos_nxt;
  logic [TB-1:0]     cd_r, cd_nxt;
  logic [TB-1:0]     lb_r, lb_nxt;
  logic [TB-1:0]     lf_r, lf_nxt;
  ppc_pkg::status_t  status_r, status_nxt;

  logic [TB-1:0]     amt;
  logic [TB-1:0]     lend;
  logic [TB:0]       pos_sum;
  logic [TB:0]       lb_sum;
  logic [TB-1:0]     pos_sat;
  logic [TB-1:0]     lb_sat;
  logic              seek;
  logic              cd_done;
  logic              rejected;

  assign amt     = TB'(cmd.amount);
  assign lend    = TB'(cmd.loop_end_value);
  assign pos_sum = {1'b0, pos_r} + {1'b0, amt};
  assign lb_sum  = {1'b0, lb_r} + {1'b0, amt};
  assign pos_sat = pos_sum[TB] ? {TB{1'b1}} : pos_sum[TB-1:0];
  assign lb_sat  = lb_sum[TB] ? {TB{1'b1}} : lb_sum[TB-1:0];

  always_comb begin
    pos_nxt    = pos_r;
    cd_nxt     = cd_r;
    lb_nxt     = lb_r;
    lf_nxt     = lf_r;
    status_nxt = status_r;
    seek       = 1'b0;
    cd_done    = 1'b0;
    rejected   = 1'b0;
    case (ppc_pkg::mode_t'(cmd.mode))
      ppc_pkg::MODE_ADVANCE: begin
        if (status_r == ppc_pkg::ST_RUNNING) begin
          if (cd_r != '0 && amt < cd_r) begin
            cd_nxt = cd_r - amt;
          end else begin
            if (cd_r != '0) begin
              cd_nxt  = '0;
              cd_done = 1'b1;
            end
            if (lb_r < lf_r && pos_sat >= lf_r) begin
              seek    = (pos_r != lb_r);
              pos_nxt = lb_sat;
            end else if (pos_sat >= duration_r) begin
              pos_nxt    = duration_r;
              status_nxt = ppc_pkg::ST_PAUSED;
            end else begin
              pos_nxt = pos_sat;
            end
          end
        end
      end
      ppc_pkg::MODE_START: begin
        status_nxt = ppc_pkg::ST_RUNNING;
      end
      ppc_pkg::MODE_STOP: begin
        status_nxt = ppc_pkg::ST_STOPPED;
        seek       = (pos_r != '0);
        pos_nxt    = '0;
        cd_nxt     = '0;
      end
      ppc_pkg::MODE_PAUSE: begin
        status_nxt = ppc_pkg::ST_PAUSED;
      end
      ppc_pkg::MODE_RESUME: begin
        status_nxt = ppc_pkg::ST_RUNNING;
      end
      ppc_pkg::MODE_SEEK: begin
        seek    = (pos_r != amt);
        pos_nxt = amt;
      end
      ppc_pkg::MODE_RESET: begin
        seek    = (pos_r != '0);
        pos_nxt = '0;
        lb_nxt  = '0;
        lf_nxt  = '0;
        cd_nxt  = '0;
      end
      ppc_pkg::MODE_SET_LOOP: begin
        if (amt >= lend) begin
          rejected = 1'b1;
        end else begin
          lb_nxt = amt;
          lf_nxt = lend;
        end
      end
      ppc_pkg::MODE_COUNTDOWN: begin
        cd_nxt = amt;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.position         = ppc_pkg::FIELD_BITS'(pos_nxt);
    res.play_status      = status_nxt;
    res.position_changed = (pos_nxt != pos_r) || seek;
    res.seek_happened    = seek;
    res.countdown_done   = cd_done;
    res.loop_rejected    = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duration_r <= '0;
    end else if (cfg_wr_en) begin
      duration_r <= TB'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      cd_r     <= '0;
      lb_r     <= '0;
      lf_r     <= '0;
      status_r <= ppc_pkg::ST_STOPPED;
    end else if (step) begin
      pos_r    <= pos_nxt;
      cd_r     <= cd_nxt;
      lb_r     <= lb_nxt;
      lf_r     <= lf_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/ppc_out_reg.sv
// result register for the output transfer
`default_nettype none

module ppc_out_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire ppc_pkg::res_t                  res,
  output logic                                can_take,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ppc_pkg::FIELD_BITS-1:0]      out_position,
  output logic [1:0]                          out_play_status,
  output logic                                out_position_changed,
  output logic                                out_seek_happened,
  output logic                                out_countdown_done,
  output logic                                out_loop_rejected
);

  logic          valid_r;
  ppc_pkg::res_t res_r;

  assign can_take             = !valid_r || out_ready;
  assign out_valid            = valid_r;
  assign out_position         = res_r.position;
  assign out_play_status      = res_r.play_status;
  assign out_position_changed = res_r.position_changed;
  assign out_seek_happened    = res_r.seek_happened;
  assign out_countdown_done   = res_r.countdown_done;
  assign out_loop_rejected    = res_r.loop_rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_take) begin
      valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
